[rtl/plru_pkg.sv]
// ----------------------------------------------------------------------------
// plru_pkg
// Shared types and constants for the page buffer LRU manager.
// ----------------------------------------------------------------------------
package plru_pkg;

  localparam int FRAMES_DEF = 64;
  localparam int OP_W       = 2;
  localparam int TID_W      = 10;
  localparam int PAGE_W     = 32;
  localparam int FIDX_W     = 6;
  localparam int STAT_W     = 3;
  localparam int CFG_W      = 7;
  localparam int TAG_W      = TID_W + PAGE_W;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_FETCH   = 2'd0,
    OP_DIRTY   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_FLUSH   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT    = 3'd0,
    ST_MISS   = 3'd1,
    ST_ALLPIN = 3'd2,
    ST_HDR    = 3'd3,
    ST_BUSY   = 3'd4,
    ST_DONE   = 3'd5
  } stat_t;

  // Kind of result the datapath builds into the output register.
  typedef enum logic [3:0] {
    K_HDR,
    K_HIT,
    K_BUSY,
    K_NEW,
    K_EVICT,
    K_ALLPIN,
    K_DONE,
    K_FL_PEND,
    K_FL_LAST,
    K_FL_NONE
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_RESULT,
    S_RERANK,
    S_FL_CHK,
    S_FL_GOT,
    S_FL_END
  } state_t;

  typedef struct packed {
    logic  accept;
    logic  scan_run;
    logic  rr_run;
    logic  rr_fin;
    logic  emit;
    logic  commit;
    logic  fl_read;
    logic  fl_skip;
    logic  fl_load;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic in_hdr;
    logic scan_done;
    logic hit;
    logic hit_pinned;
    logic free_avail;
    logic vic_found;
    logic fl_end;
    logic fl_dirty;
    logic pend_v;
    logic slot_free;
  } sts_t;

endpackage

[rtl/page_buffer_lru_manager.sv]
// ----------------------------------------------------------------------------
// page_buffer_lru_manager
// Buffer pool frame table with LRU replacement, pinning and flush.
// ----------------------------------------------------------------------------
// Usage: a request (op, tbl_id, page_number, frame_index) is taken on the
// input channel when in_valid is high and in_stall is low. Each request
// produces one result transaction, and a flush produces one per dirty frame
// (at least one); last marks the final result of a request.
// Passes: mark dirty, release and a header-page fetch need no scan. A fetch
// scans the tags and ranks of the allocated frames, then reorders the ranks
// in a rerank pass on a hit (pinned or not) or an eviction. A flush walks the
// dirty marks of the allocated frames. The tag and rank memories, each with
// one read and one write port, are read one frame per cycle during a scan.
// A new request is accepted while the last result still waits in the output
// register; a stalled receiver holds the block in its current pass.
// Reset: synchronous; empties the pool, clears all marks and sets
// frames_in_use to 64. No clearing pass is needed.
// Configuration: APB register 0 (frames_in_use) at byte address 0.
// ----------------------------------------------------------------------------
module page_buffer_lru_manager #(
  parameter int FRAMES = plru_pkg::FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plru_pkg::PADDR_W-1:0]  paddr,
  input  logic [plru_pkg::PDATA_W-1:0]  pwdata,
  output logic [plru_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [plru_pkg::OP_W-1:0]     op,
  input  logic [plru_pkg::TID_W-1:0]    tbl_id,
  input  logic [plru_pkg::PAGE_W-1:0]   page_number,
  input  logic [plru_pkg::FIDX_W-1:0]   frame_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [plru_pkg::STAT_W-1:0]   status,
  output logic [plru_pkg::FIDX_W-1:0]   frame_out,
  output logic                          writeback,
  output logic [plru_pkg::TID_W-1:0]    wb_table,
  output logic [plru_pkg::PAGE_W-1:0]   wb_page,
  output logic                          load_needed,
  output logic                          last
);

  plru_pkg::cmd_t             cmd;
  plru_pkg::sts_t             sts;
  logic                       cfg_we;
  logic [plru_pkg::CFG_W-1:0] cfg_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0
                  : {{(plru_pkg::PDATA_W-plru_pkg::CFG_W){1'b0}}, cfg_rdata};

  plru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  plru_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[plru_pkg::CFG_W-1:0]),
    .cfg_rdata   (cfg_rdata),
    .op          (op),
    .tbl_id      (tbl_id),
    .page_number (page_number),
    .frame_index (frame_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .frame_out   (frame_out),
    .writeback   (writeback),
    .wb_table    (wb_table),
    .wb_page     (wb_page),
    .load_needed (load_needed),
    .last        (last)
  );

endmodule

[rtl/plru_ctrl.sv]
// ----------------------------------------------------------------------------
// plru_ctrl
// Sequencer for lookup, commit, rerank and flush passes of the frame table.
// ----------------------------------------------------------------------------
module plru_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  plru_pkg::sts_t sts,
  output plru_pkg::cmd_t cmd
);

  plru_pkg::state_t state, state_next;
  plru_pkg::kind_t  kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plru_pkg::S_IDLE;
      kind  <= plru_pkg::K_HDR;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  assign in_stall = (state != plru_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    cmd.kind   = kind;
    case (state)
      plru_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (sts.in_op)
            plru_pkg::OP_FETCH: begin
              if (sts.in_hdr) begin
                kind_next  = plru_pkg::K_HDR;
                state_next = plru_pkg::S_RESULT;
              end else begin
                state_next = plru_pkg::S_LOOKUP;
              end
            end
            plru_pkg::OP_FLUSH: state_next = plru_pkg::S_FL_CHK;
            default: begin
              kind_next  = plru_pkg::K_DONE;
              state_next = plru_pkg::S_RESULT;
            end
          endcase
        end
      end
      plru_pkg::S_LOOKUP: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_next = plru_pkg::S_RESULT;
          if (sts.hit) begin
            kind_next = sts.hit_pinned ? plru_pkg::K_BUSY : plru_pkg::K_HIT;
          end else if (sts.free_avail) begin
            kind_next = plru_pkg::K_NEW;
          end else if (sts.vic_found) begin
            kind_next = plru_pkg::K_EVICT;
          end else begin
            kind_next = plru_pkg::K_ALLPIN;
          end
        end
      end
      plru_pkg::S_RESULT: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.commit = 1'b1;
          if (kind inside {plru_pkg::K_HIT, plru_pkg::K_BUSY, plru_pkg::K_EVICT}) begin
            state_next = plru_pkg::S_RERANK;
          end else begin
            state_next = plru_pkg::S_IDLE;
          end
        end
      end
      plru_pkg::S_RERANK: begin
        cmd.rr_run = 1'b1;
        if (sts.scan_done) begin
          cmd.rr_fin = 1'b1;
          state_next = plru_pkg::S_IDLE;
        end
      end
      plru_pkg::S_FL_CHK: begin
        if (sts.fl_end) begin
          state_next = plru_pkg::S_FL_END;
        end else if (sts.fl_dirty) begin
          cmd.fl_read = 1'b1;
          state_next  = plru_pkg::S_FL_GOT;
        end else begin
          cmd.fl_skip = 1'b1;
        end
      end
      plru_pkg::S_FL_GOT: begin
        cmd.kind = plru_pkg::K_FL_PEND;
        if (!sts.pend_v) begin
          cmd.fl_load = 1'b1;
          state_next  = plru_pkg::S_FL_CHK;
        end else if (sts.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.fl_load = 1'b1;
          state_next  = plru_pkg::S_FL_CHK;
        end
      end
      plru_pkg::S_FL_END: begin
        cmd.kind = sts.pend_v ? plru_pkg::K_FL_LAST : plru_pkg::K_FL_NONE;
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = plru_pkg::S_IDLE;
        end
      end
      default: state_next = plru_pkg::S_IDLE;
    endcase
  end

endmodule

[rtl/plru_dp.sv]
// ----------------------------------------------------------------------------
// plru_dp
// Frame table datapath: tag and rank memories, marks, scan counter, result.
// ----------------------------------------------------------------------------
module plru_dp #(
  parameter int FRAMES = plru_pkg::FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  plru_pkg::cmd_t                cmd,
  output plru_pkg::sts_t                sts,
  // configuration
  input  logic                          cfg_we,
  input  logic [plru_pkg::CFG_W-1:0]    cfg_wdata,
  output logic [plru_pkg::CFG_W-1:0]    cfg_rdata,
  // request
  input  logic [plru_pkg::OP_W-1:0]     op,
  input  logic [plru_pkg::TID_W-1:0]    tbl_id,
  input  logic [plru_pkg::PAGE_W-1:0]   page_number,
  input  logic [plru_pkg::FIDX_W-1:0]   frame_index,
  // result
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [plru_pkg::STAT_W-1:0]   status,
  output logic [plru_pkg::FIDX_W-1:0]   frame_out,
  output logic                          writeback,
  output logic [plru_pkg::TID_W-1:0]    wb_table,
  output logic [plru_pkg::PAGE_W-1:0]   wb_page,
  output logic                          load_needed,
  output logic                          last
);

  localparam int FW = $clog2(FRAMES);
  localparam int AW = $clog2(FRAMES + 1);

  logic [plru_pkg::TAG_W-1:0] tag_mem [FRAMES];
  logic [FW-1:0]              rank_mem [FRAMES];
  logic [plru_pkg::TAG_W-1:0] tag_q;
  logic [FW-1:0]              rank_q;

  logic [plru_pkg::CFG_W-1:0]  frames_in_use;
  logic [AW-1:0]               alloc;
  logic [AW-1:0]               limit;
  logic [FRAMES-1:0]           dirty;
  logic [FRAMES-1:0]           pin;

  plru_pkg::op_t               op_r;
  logic [plru_pkg::TID_W-1:0]  tid_r;
  logic [plru_pkg::PAGE_W-1:0] pn_r;
  logic [plru_pkg::FIDX_W-1:0] fi_r;

  logic [AW-1:0]              idx;
  logic                       d_v;
  logic [FW-1:0]              d_idx;
  logic                       hit_f;
  logic [FW-1:0]              hit_i;
  logic [FW-1:0]              hit_r;
  logic                       vic_f;
  logic [FW-1:0]              vic_i;
  logic [FW-1:0]              vic_r;
  logic [plru_pkg::TAG_W-1:0] vic_tag;
  logic [FW-1:0]              rr_i;
  logic [FW-1:0]              rr_r;
  logic                       pend_v;
  logic [FW-1:0]              pend_i;
  logic [plru_pkg::TAG_W-1:0] pend_tag;

  logic                       issue;
  logic                       rd_en;
  logic                       fi_ok;
  logic [FW-1:0]              fi_ix;
  logic [FW-1:0]              alloc_ix;
  logic                       tag_we;
  logic [FW-1:0]              tag_wa;
  logic                       rank_we;
  logic [FW-1:0]              rank_wa;
  logic [FW-1:0]              rank_wd;
  logic                       slot_free;

  logic [plru_pkg::STAT_W-1:0] r_status;
  logic [plru_pkg::FIDX_W-1:0] r_frame;
  logic                        r_wb;
  logic [plru_pkg::TAG_W-1:0]  r_tag;
  logic                        r_load;
  logic                        r_last;

  assign cfg_rdata = frames_in_use;
  assign slot_free = !out_valid || !out_stall;
  assign issue     = (cmd.scan_run || cmd.rr_run) && (idx < alloc);
  assign rd_en     = issue || cmd.fl_read;
  assign fi_ok     = ({{(32-plru_pkg::FIDX_W){1'b0}}, fi_r} < 32'(alloc));
  assign fi_ix     = FW'(fi_r);
  assign alloc_ix  = FW'(alloc);

  always_comb begin
    if (frames_in_use == '0) begin
      limit = AW'(1);
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      limit = AW'(FRAMES);
    end else begin
      limit = AW'(frames_in_use);
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.in_op      = plru_pkg::op_t'(op);
    sts.in_hdr     = (page_number == '0);
    sts.scan_done  = (idx >= alloc) && !d_v;
    sts.hit        = hit_f;
    sts.hit_pinned = pin[hit_i];
    sts.free_avail = (alloc < limit);
    sts.vic_found  = vic_f;
    sts.fl_end     = (idx >= alloc);
    sts.fl_dirty   = dirty[idx[FW-1:0]];
    sts.pend_v     = pend_v;
    sts.slot_free  = slot_free;
  end

  // Memory write port selection; the controller keeps the sources apart.
  always_comb begin
    tag_we  = 1'b0;
    tag_wa  = vic_i;
    rank_we = 1'b0;
    rank_wa = d_idx;
    rank_wd = rank_q - FW'(1);
    if (cmd.commit && cmd.kind == plru_pkg::K_NEW) begin
      tag_we  = 1'b1;
      tag_wa  = alloc_ix;
      rank_we = 1'b1;
      rank_wa = alloc_ix;
      rank_wd = alloc_ix;
    end else if (cmd.commit && cmd.kind == plru_pkg::K_EVICT) begin
      tag_we = 1'b1;
    end else if (cmd.rr_fin) begin
      rank_we = 1'b1;
      rank_wa = rr_i;
      rank_wd = FW'(alloc - AW'(1));
    end else if (cmd.rr_run && d_v && (rank_q > rr_r)) begin
      rank_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= {tid_r, pn_r};
    end
    if (rd_en) begin
      tag_q <= tag_mem[idx[FW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    if (issue) begin
      rank_q <= rank_mem[idx[FW-1:0]];
    end
  end

  // Control state: configuration, fill count, marks, scan and output valid.
  // No read is issued while a request is accepted or committed, so the read
  // flag drops there by itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= plru_pkg::CFG_W'(plru_pkg::FRAMES_DEF);
      alloc         <= '0;
      dirty         <= '0;
      pin           <= '0;
      idx           <= '0;
      d_v           <= 1'b0;
      hit_f         <= 1'b0;
      vic_f         <= 1'b0;
      pend_v        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_wdata;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      d_v <= issue;
      if (issue) begin
        idx <= idx + AW'(1);
      end

      if (cmd.accept) begin
        idx    <= '0;
        hit_f  <= 1'b0;
        vic_f  <= 1'b0;
        pend_v <= 1'b0;
      end

      if (cmd.scan_run && d_v) begin
        if (!hit_f && tag_q == {tid_r, pn_r}) begin
          hit_f <= 1'b1;
        end
        if (!pin[d_idx] && (!vic_f || rank_q < vic_r)) begin
          vic_f <= 1'b1;
        end
      end

      if (cmd.commit) begin
        idx <= '0;
        case (cmd.kind)
          plru_pkg::K_HIT, plru_pkg::K_BUSY: pin[hit_i] <= 1'b1;
          plru_pkg::K_NEW: begin
            dirty[alloc_ix] <= 1'b0;
            pin[alloc_ix]   <= 1'b1;
            alloc           <= alloc + AW'(1);
          end
          plru_pkg::K_EVICT: begin
            dirty[vic_i] <= 1'b0;
            pin[vic_i]   <= 1'b1;
          end
          plru_pkg::K_DONE: begin
            if (fi_ok && op_r == plru_pkg::OP_DIRTY) begin
              dirty[fi_ix] <= 1'b1;
            end else if (fi_ok && op_r == plru_pkg::OP_RELEASE) begin
              pin[fi_ix] <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (cmd.fl_skip) begin
        idx <= idx + AW'(1);
      end
      if (cmd.fl_read) begin
        dirty[idx[FW-1:0]] <= 1'b0;
      end
      if (cmd.fl_load) begin
        pend_v <= 1'b1;
        idx    <= idx + AW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    d_idx <= idx[FW-1:0];
    if (cmd.accept) begin
      op_r  <= plru_pkg::op_t'(op);
      tid_r <= tbl_id;
      pn_r  <= page_number;
      fi_r  <= frame_index;
    end
    if (cmd.scan_run && d_v) begin
      if (!hit_f && tag_q == {tid_r, pn_r}) begin
        hit_i <= d_idx;
        hit_r <= rank_q;
      end
      if (!pin[d_idx] && (!vic_f || rank_q < vic_r)) begin
        vic_i   <= d_idx;
        vic_r   <= rank_q;
        vic_tag <= tag_q;
      end
    end
    if (cmd.commit) begin
      if (cmd.kind == plru_pkg::K_EVICT) begin
        rr_i <= vic_i;
        rr_r <= vic_r;
      end else begin
        rr_i <= hit_i;
        rr_r <= hit_r;
      end
    end
    if (cmd.fl_load) begin
      pend_i   <= idx[FW-1:0];
      pend_tag <= tag_q;
    end
    if (cmd.emit) begin
      status      <= r_status;
      frame_out   <= r_frame;
      writeback   <= r_wb;
      wb_table    <= r_tag[plru_pkg::TAG_W-1:plru_pkg::PAGE_W];
      wb_page     <= r_tag[plru_pkg::PAGE_W-1:0];
      load_needed <= r_load;
      last        <= r_last;
    end
  end

  // Result assembly for the kind the controller selects.
  always_comb begin
    r_status = plru_pkg::ST_DONE;
    r_frame  = '0;
    r_wb     = 1'b0;
    r_tag    = '0;
    r_load   = 1'b0;
    r_last   = 1'b1;
    case (cmd.kind)
      plru_pkg::K_HDR:    r_status = plru_pkg::ST_HDR;
      plru_pkg::K_HIT: begin
        r_status = plru_pkg::ST_HIT;
        r_frame  = plru_pkg::FIDX_W'(hit_i);
      end
      plru_pkg::K_BUSY: begin
        r_status = plru_pkg::ST_BUSY;
        r_frame  = plru_pkg::FIDX_W'(hit_i);
      end
      plru_pkg::K_NEW: begin
        r_status = plru_pkg::ST_MISS;
        r_frame  = plru_pkg::FIDX_W'(alloc);
        r_load   = 1'b1;
      end
      plru_pkg::K_EVICT: begin
        r_status = plru_pkg::ST_MISS;
        r_frame  = plru_pkg::FIDX_W'(vic_i);
        r_load   = 1'b1;
        r_wb     = dirty[vic_i];
        r_tag    = dirty[vic_i] ? vic_tag : '0;
      end
      plru_pkg::K_ALLPIN: r_status = plru_pkg::ST_ALLPIN;
      plru_pkg::K_DONE:   r_frame  = fi_r;
      plru_pkg::K_FL_PEND, plru_pkg::K_FL_LAST: begin
        r_frame = plru_pkg::FIDX_W'(pend_i);
        r_wb    = 1'b1;
        r_tag   = pend_tag;
        r_last  = (cmd.kind == plru_pkg::K_FL_LAST);
      end
      default: ;
    endcase
  end

  // The fill count can never pass the pool size.
  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cmd.kind == plru_pkg::K_NEW |-> alloc < AW'(FRAMES))
    else $error("frame allocated beyond the pool");

  // A result is only loaded when the output register can take it.
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending transaction");

  // The frame handed out by a hit or an eviction is pinned afterwards.
  a_pin_after: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && (cmd.kind == plru_pkg::K_HIT || cmd.kind == plru_pkg::K_EVICT)
    |=> pin[rr_i])
    else $error("committed frame not pinned");

endmodule
